[hdl/ahx_pkg.sv]
// ----------------------------------------------------------------------------
// ahx_pkg
// Shared constants, types, microcode table and helpers for the ASCII
// decimal/hexadecimal converter.
// ----------------------------------------------------------------------------
package ahx_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_NINE    = 8'h39;
    localparam logic [7:0] ASCII_X       = 8'h78;
    localparam logic [7:0] ASCII_A       = 8'h41;
    localparam logic [7:0] ASCII_F       = 8'h46;
    localparam logic [7:0] ASCII_MINUS   = 8'h2D;
    localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;

    // sequencer steps
    localparam int PC_W = 3;
    typedef logic [PC_W-1:0] pc_t;
    localparam pc_t S_IDLE    = 3'd0;
    localparam pc_t S_ROUTE   = 3'd1;
    localparam pc_t S_HEX0    = 3'd2;
    localparam pc_t S_HEX1    = 3'd3;
    localparam pc_t S_SKIP    = 3'd4;
    localparam pc_t S_EMITD   = 3'd5;
    localparam pc_t S_DD_INIT = 3'd6;
    localparam pc_t S_DD_STEP = 3'd7;

    // datapath operations
    typedef logic [2:0] op_t;
    localparam op_t OP_NONE     = 3'd0;
    localparam op_t OP_ACCEPT   = 3'd1;
    localparam op_t OP_LOAD_CNT = 3'd2;
    localparam op_t OP_SKIP     = 3'd3;
    localparam op_t OP_SHIFT    = 3'd4;
    localparam op_t OP_DD_INIT  = 3'd5;
    localparam op_t OP_DD_STEP  = 3'd6;

    // jump conditions
    typedef logic [2:0] cond_t;
    localparam cond_t C_ALWAYS    = 3'd0;
    localparam cond_t C_START     = 3'd1;
    localparam cond_t C_MODE_X    = 3'd2;
    localparam cond_t C_ZERO      = 3'd3;
    localparam cond_t C_SKIP_MORE = 3'd4;
    localparam cond_t C_CNT1      = 3'd5;

    // output character select
    typedef logic [1:0] emit_t;
    localparam emit_t EM_NONE  = 2'd0;
    localparam emit_t EM_ZERO  = 2'd1;
    localparam emit_t EM_X     = 2'd2;
    localparam emit_t EM_DIGIT = 2'd3;

    typedef struct packed {
        op_t   op;
        emit_t emit;
        cond_t cond;
        pc_t   t_true;
        pc_t   t_false;
    } ucode_t;

    typedef struct packed {
        logic seen_x;
        logic negative;
    } tok_status_t;

    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t w;
        unique case (pc)
            S_IDLE:    w = '{op: OP_ACCEPT,   emit: EM_NONE,  cond: C_START,
                             t_true: S_ROUTE,   t_false: S_IDLE};
            S_ROUTE:   w = '{op: OP_NONE,     emit: EM_NONE,  cond: C_MODE_X,
                             t_true: S_DD_INIT, t_false: S_HEX0};
            S_HEX0:    w = '{op: OP_LOAD_CNT, emit: EM_ZERO,  cond: C_ALWAYS,
                             t_true: S_HEX1,    t_false: S_HEX1};
            S_HEX1:    w = '{op: OP_NONE,     emit: EM_X,     cond: C_ZERO,
                             t_true: S_IDLE,    t_false: S_SKIP};
            S_SKIP:    w = '{op: OP_SKIP,     emit: EM_NONE,  cond: C_SKIP_MORE,
                             t_true: S_SKIP,    t_false: S_EMITD};
            S_EMITD:   w = '{op: OP_SHIFT,    emit: EM_DIGIT, cond: C_CNT1,
                             t_true: S_IDLE,    t_false: S_EMITD};
            S_DD_INIT: w = '{op: OP_DD_INIT,  emit: EM_NONE,  cond: C_ALWAYS,
                             t_true: S_DD_STEP, t_false: S_DD_STEP};
            S_DD_STEP: w = '{op: OP_DD_STEP,  emit: EM_NONE,  cond: C_CNT1,
                             t_true: S_SKIP,    t_false: S_DD_STEP};
            default:   w = '{op: OP_NONE,     emit: EM_NONE,  cond: C_ALWAYS,
                             t_true: S_IDLE,    t_false: S_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [7:0] nib_ascii(input logic [3:0] d);
        logic [7:0] d8;
        d8 = {4'b0000, d};
        return (d > 4'd9) ? d8 + HEX_ALPHA_OFS : d8 + ASCII_ZERO;
    endfunction

    // decimal digits needed for the largest w-bit value
    function automatic int dec_digits(input int w);
        longint unsigned v;
        int n;
        v = {64{1'b1}} >> (64 - w);
        n = 0;
        while (v != 0) begin
            n++;
            v = v / 10;
        end
        return n;
    endfunction

endpackage

[hdl/ascii_dec_hex_converter_core.sv]
// ----------------------------------------------------------------------------
// ascii_dec_hex_converter_core
// Converts a number token between decimal and hex ASCII text under control
// of a small microcode table.
// ----------------------------------------------------------------------------
// Characters are taken one per cycle while a token is being read. On the
// token's last character the input stalls while the result is produced: a
// decimal token turns into "0x" and its hex digits (just "0x" for a zero
// value), a hex token ("...x...") into decimal digits. Leading zero digits
// of the fixed-size digit field are skipped before the digits are sent.
// Decimal digits come from a double-dabble unit, which takes one bit of the
// value per cycle; every output character holds the sequencer until the
// output slot is free. A token starting with '-' is consumed with no result
// and without stalling the input.
// ----------------------------------------------------------------------------
module ascii_dec_hex_converter_core
    import ahx_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_in,
    input  logic       token_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] char_out,
    output logic       last_char
);

    localparam int NIB  = (VALUE_WIDTH + 3) / 4;
    localparam int DEC  = dec_digits(VALUE_WIDTH);
    localparam int NDIG = (NIB > DEC) ? NIB : DEC;
    localparam int DW   = 4 * NDIG;
    localparam int CMAX = (VALUE_WIDTH > NDIG) ? VALUE_WIDTH : NDIG;
    localparam int CW   = $clog2(CMAX + 1);

    pc_t                    pc_reg, pc_next;
    logic                   mode_x_reg, mode_x_next;
    logic [VALUE_WIDTH-1:0] sh_reg, sh_next;
    logic [DW-1:0]          dig_reg, dig_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   out_valid_reg;
    logic [7:0]             char_reg, char_next;
    logic                   last_reg, last_next;

    logic [VALUE_WIDTH-1:0] hex_value;
    logic [VALUE_WIDTH-1:0] dec_value;
    tok_status_t            st;

    ucode_t        uw;
    logic          accept;
    logic          slot_free;
    logic          advance;
    logic          take;
    logic [3:0]    top_nib;
    logic          dig_zero;
    logic          cnt_one;
    logic          skip_more;
    logic [DW-1:0] adj;

    assign in_stall = (pc_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    ahx_accum #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_in   (char_in),
        .token_end (token_end),
        .hex_value (hex_value),
        .dec_value (dec_value),
        .status    (st)
    );

    assign uw        = ucode_rom(pc_reg);
    assign slot_free = !out_valid_reg || !out_stall;
    assign advance   = (uw.emit == EM_NONE) || slot_free;
    assign top_nib   = dig_reg[DW-1 -: 4];
    assign dig_zero  = (dig_reg == '0);
    assign cnt_one   = (cnt_reg == CW'(1));
    assign skip_more = (top_nib == 4'd0) && !cnt_one;

    // add-3 correction on every BCD digit before the shift
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            adj[4*i +: 4] = (dig_reg[4*i +: 4] >= 4'd5) ? dig_reg[4*i +: 4] + 4'd3
                                                        : dig_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        unique case (uw.cond)
            C_ALWAYS:    take = 1'b1;
            C_START:     take = accept && token_end && !st.negative;
            C_MODE_X:    take = mode_x_reg;
            C_ZERO:      take = dig_zero;
            C_SKIP_MORE: take = skip_more;
            C_CNT1:      take = cnt_one;
            default:     take = 1'b1;
        endcase
        pc_next = advance ? (take ? uw.t_true : uw.t_false) : pc_reg;
    end

    always_comb
    begin
        unique case (uw.emit)
            EM_ZERO:
            begin
                char_next = ASCII_ZERO;
                last_next = 1'b0;
            end
            EM_X:
            begin
                char_next = ASCII_X;
                last_next = dig_zero;
            end
            EM_DIGIT:
            begin
                char_next = nib_ascii(top_nib);
                last_next = cnt_one;
            end
            default:
            begin
                char_next = char_reg;
                last_next = last_reg;
            end
        endcase
    end

    always_comb
    begin
        mode_x_next = mode_x_reg;
        sh_next     = sh_reg;
        dig_next    = dig_reg;
        cnt_next    = cnt_reg;
        if (advance)
        begin
            unique case (uw.op)
                OP_NONE: ;
                OP_ACCEPT:
                begin
                    if (accept && token_end)
                    begin
                        sh_next     = hex_value;
                        dig_next    = DW'(dec_value);
                        mode_x_next = st.seen_x;
                    end
                end
                OP_LOAD_CNT:
                    cnt_next = CW'(NDIG);
                OP_SKIP:
                begin
                    if (skip_more)
                    begin
                        dig_next = dig_reg << 4;
                        cnt_next = cnt_reg - CW'(1);
                    end
                end
                OP_SHIFT:
                begin
                    dig_next = dig_reg << 4;
                    cnt_next = cnt_reg - CW'(1);
                end
                OP_DD_INIT:
                begin
                    dig_next = '0;
                    cnt_next = CW'(VALUE_WIDTH);
                end
                OP_DD_STEP:
                begin
                    dig_next = {adj[DW-2:0], sh_reg[VALUE_WIDTH-1]};
                    sh_next  = sh_reg << 1;
                    // last bit: reload the count for the digit scan
                    cnt_next = cnt_one ? CW'(NDIG) : cnt_reg - CW'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= S_IDLE;
            mode_x_reg    <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg     <= pc_next;
            mode_x_reg <= mode_x_next;
            cnt_reg    <= cnt_next;
            if (advance && (uw.emit != EM_NONE))
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        dig_reg <= dig_next;
        // the output item holds until the slot frees up
        if (advance && (uw.emit != EM_NONE))
        begin
            char_reg <= char_next;
            last_reg <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign char_out  = char_reg;
    assign last_char = last_reg;

    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == S_SKIP || pc_reg == S_EMITD) |-> (cnt_reg != '0))
        else $error("digit count is zero during digit scan");

    a_bcd_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == S_EMITD && mode_x_reg) |-> (top_nib <= 4'd9))
        else $error("decimal digit out of range");

    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(pc_reg) != S_IDLE))
        else $error("output item raised from the idle step");

endmodule

[hdl/ahx_accum.sv]
// ----------------------------------------------------------------------------
// ahx_accum
// Per-character token state: hex value after the first 'x', leading decimal
// digits, and token flags. Presents the values updated by the current char.
// ----------------------------------------------------------------------------
module ahx_accum
    import ahx_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [7:0]             char_in,
    input  logic                   token_end,
    output logic [VALUE_WIDTH-1:0] hex_value,
    output logic [VALUE_WIDTH-1:0] dec_value,
    output tok_status_t            status
);

    logic [VALUE_WIDTH-1:0] hex_reg, hex_next;
    logic [VALUE_WIDTH-1:0] dec_reg, dec_next;
    logic seen_x_reg, seen_x_next;
    logic stopped_reg, stopped_next;
    logic start_reg;
    logic neg_reg, neg_next;

    logic [VALUE_WIDTH-1:0] c_w;
    logic [VALUE_WIDTH-1:0] hex_digit;
    logic                   is_alpha;
    logic                   is_dig;

    always_comb
    begin
        c_w       = VALUE_WIDTH'(char_in);
        is_alpha  = (char_in >= ASCII_A) && (char_in <= ASCII_F);
        is_dig    = (char_in >= ASCII_ZERO) && (char_in <= ASCII_NINE);
        // below '0' this wraps, as the digit value is taken modulo 2^W
        hex_digit = is_alpha ? c_w - VALUE_WIDTH'(HEX_ALPHA_OFS)
                             : c_w - VALUE_WIDTH'(ASCII_ZERO);

        hex_next     = seen_x_reg ? (hex_reg << 4) + hex_digit : hex_reg;
        seen_x_next  = seen_x_reg | (char_in == ASCII_X);
        dec_next     = (!stopped_reg && is_dig)
                     ? (dec_reg << 3) + (dec_reg << 1) + (c_w - VALUE_WIDTH'(ASCII_ZERO))
                     : dec_reg;
        stopped_next = stopped_reg | !is_dig;
        neg_next     = neg_reg | (start_reg && (char_in == ASCII_MINUS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hex_reg     <= '0;
            dec_reg     <= '0;
            seen_x_reg  <= 1'b0;
            stopped_reg <= 1'b0;
            start_reg   <= 1'b1;
            neg_reg     <= 1'b0;
        end
        else if (accept)
        begin
            if (token_end)
            begin
                hex_reg     <= '0;
                dec_reg     <= '0;
                seen_x_reg  <= 1'b0;
                stopped_reg <= 1'b0;
                start_reg   <= 1'b1;
                neg_reg     <= 1'b0;
            end
            else
            begin
                hex_reg     <= hex_next;
                dec_reg     <= dec_next;
                seen_x_reg  <= seen_x_next;
                stopped_reg <= stopped_next;
                start_reg   <= 1'b0;
                neg_reg     <= neg_next;
            end
        end
    end

    assign hex_value = hex_next;
    assign dec_value = dec_next;
    assign status    = '{seen_x: seen_x_next, negative: neg_next};

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for ascii_dec_hex_converter_core. Number tokens go in one
// character per item and the converted text comes back one character per
// item. A scoreboard predicts every output character and compares it with
// what the core sends. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb
    import ahx_pkg::*;
();

    localparam int VW         = VALUE_WIDTH_DEF;
    localparam int RAND_ITEMS = 200;
    localparam int IDLE_LIMIT = 3000;
    localparam int MAX_PRINTS = 30;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] char_in;
    logic       token_end;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] char_out;
    logic       last_char;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the token being read and queues the text it becomes
    // ------------------------------------------------------------------------
    class conv_scoreboard;
        logic [7:0] text_q[$];
        logic       last_q[$];
        logic [VW-1:0] dec_acc;
        logic [VW-1:0] hex_acc;
        bit seen_x;
        bit dec_done;
        bit tok_start;
        bit neg_tok;
        int errors;
        int chars_in;
        int chars_out;
        int dec_tokens;
        int hex_tokens;
        int neg_tokens;

        function new();
            errors     = 0;
            chars_in   = 0;
            chars_out  = 0;
            dec_tokens = 0;
            hex_tokens = 0;
            neg_tokens = 0;
            clear_token();
        endfunction

        function void clear_token();
            dec_acc   = '0;
            hex_acc   = '0;
            seen_x    = 0;
            dec_done  = 0;
            tok_start = 1;
            neg_tok   = 0;
        endfunction

        function int pending();
            return text_q.size();
        endfunction

        function void push_char(logic [7:0] ch, logic last);
            text_q = {text_q, ch};
            last_q = {last_q, last};
        endfunction

        function void queue_hex_text(logic [VW-1:0] v);
            logic [VW-1:0] t;
            logic [3:0]    nib;
            int            n;
            t = v;
            n = 0;
            while (t != 0) begin
                n++;
                t = t >> 4;
            end
            push_char(ASCII_ZERO, 1'b0);
            push_char(ASCII_X, n == 0);
            for (int i = n - 1; i >= 0; i--) begin
                nib = v[4*i +: 4];
                if (nib > 4'd9)
                    push_char({4'b0000, nib} + HEX_ALPHA_OFS, i == 0);
                else
                    push_char({4'b0000, nib} + ASCII_ZERO, i == 0);
            end
        endfunction

        function void queue_dec_text(logic [VW-1:0] v);
            logic [7:0] digs[10];
            int         cnt;
            cnt = 0;
            do begin
                digs[cnt] = 8'(v % 10);
                cnt++;
                v = v / 10;
            end while (v != 0 && cnt < 10);
            for (int i = cnt - 1; i >= 0; i--)
                push_char(digs[i] + ASCII_ZERO, i == 0);
        endfunction

        function void note_input(logic [7:0] c, logic e);
            logic [VW-1:0] cv;
            logic [VW-1:0] d;
            chars_in++;
            cv = VW'(c);
            if (tok_start && c == ASCII_MINUS)
                neg_tok = 1;
            tok_start = 0;

            if (seen_x) begin
                // anything outside A..F counts as c-48, wrapping below '0'
                if (c >= ASCII_A && c <= ASCII_F)
                    d = cv - VW'(HEX_ALPHA_OFS);
                else
                    d = cv - VW'(ASCII_ZERO);
                hex_acc = hex_acc * 16 + d;
            end else if (c == ASCII_X) begin
                seen_x = 1;
            end

            if (!dec_done) begin
                if (c >= ASCII_ZERO && c <= ASCII_NINE)
                    dec_acc = dec_acc * 10 + (cv - VW'(ASCII_ZERO));
                else
                    dec_done = 1;
            end

            if (e) begin
                if (neg_tok)
                    neg_tokens++;
                else if (seen_x) begin
                    hex_tokens++;
                    queue_dec_text(hex_acc);
                end else begin
                    dec_tokens++;
                    queue_hex_text(dec_acc);
                end
                clear_token();
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("MISMATCH: %s", msg);
        endtask

        task check_result(logic [7:0] ch, logic last);
            logic [7:0] want_ch;
            logic       want_last;
            chars_out++;
            if (text_q.size() == 0) begin
                report($sformatf("unexpected char 0x%02h last=%0b", ch, last));
            end else begin
                want_ch   = text_q.pop_front();
                want_last = last_q.pop_front();
                if (ch !== want_ch)
                    report($sformatf("char_out 0x%02h, want 0x%02h (out #%0d)",
                                     ch, want_ch, chars_out));
                if (last !== want_last)
                    report($sformatf("last_char %0b, want %0b (out #%0d)",
                                     last, want_last, chars_out));
            end
        endtask
    endclass

    conv_scoreboard sb;
    logic [7:0]     tok_q[$];
    bit             tx_quiet = 0;
    bit             rx_quiet = 0;
    int             idle_cycles = 0;

    ascii_dec_hex_converter_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_in   (char_in),
        .token_end (token_end),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_out  (char_out),
        .last_char (last_char)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // watchdog: ends the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
            $display("tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    function void add_char(input logic [7:0] c);
        tok_q = {tok_q, c};
    endfunction

    task send_item(input logic [7:0] c, input logic e);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_in   <= c;
        token_end <= e;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_input(c, e);
    endtask

    task send_token();
        tx_quiet = ($urandom_range(0, 3) == 0);
        foreach (tok_q[i])
            send_item(tok_q[i], i == tok_q.size() - 1);
    endtask

    task load_str(input string s);
        tok_q = {};
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endtask

    task drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task add_digits(input int n);
        for (int i = 0; i < n; i++)
            add_char(ASCII_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // mostly well-formed numbers, some negatives and raw noise
    task make_token();
        string hexdig;
        int    kind;
        int    n;
        hexdig = "0123456789ABCDEF";
        tok_q  = {};
        kind   = $urandom_range(0, 9);
        if (kind <= 3) begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 11) : $urandom_range(1, 4);
            add_digits(n);
            if ($urandom_range(0, 3) == 0) begin
                add_char(8'($urandom_range(0, 255)));
                add_digits($urandom_range(0, 2));
            end
        end else if (kind <= 6) begin
            if ($urandom_range(0, 1) == 0)
                add_digits($urandom_range(0, 2));
            else
                add_char(ASCII_ZERO);
            add_char(ASCII_X);
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 9) : $urandom_range(0, 4);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 9))
                    0:       add_char(8'($urandom_range(0, 255)));
                    1:       add_char(8'h61 + 8'($urandom_range(0, 5)));
                    2:       add_char(ASCII_X);
                    default: add_char(hexdig[$urandom_range(0, 15)]);
                endcase
            end
        end else if (kind == 7) begin
            add_char(ASCII_MINUS);
            if ($urandom_range(0, 1) == 0)
                add_digits($urandom_range(0, 4));
            else begin
                add_char(ASCII_X);
                add_char(hexdig[$urandom_range(0, 15)]);
            end
        end else begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++)
                add_char(8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------
    initial
    begin
        int gap;
        int since_mode;
        since_mode = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (since_mode == 0) begin
                rx_quiet   = ($urandom_range(0, 3) == 0);
                since_mode = $urandom_range(8, 24);
            end
            since_mode--;
            gap = rx_quiet ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (out_valid !== 1'b1);
            sb.check_result(char_out, last_char);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        char_in     = 8'h00;
        token_end   = 1'b0;
        out_stall   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero value, negative token, bare 'x', largest values both ways,
        // and the two extreme byte codes as one-char tokens
        load_str("0");          send_token();
        load_str("-1");         send_token();
        load_str("x");          send_token();
        load_str("4294967295"); send_token();
        load_str("xFFFFFFFF");  send_token();
        tok_q = '{8'h00};       send_token();
        tok_q = '{8'hFF};       send_token();
        drain_results();

        while (sb.chars_in < RAND_ITEMS) begin
            make_token();
            send_token();
            if ($urandom_range(0, 15) == 0)
                drain_results();
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (100) @(posedge clk);

        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected chars never came", sb.pending()));
        $display("covered %0d chars in, %0d chars out, %0d mismatches",
                 sb.chars_in, sb.chars_out, sb.errors);
        $display("tokens: %0d decimal, %0d hex, %0d negative",
                 sb.dec_tokens, sb.hex_tokens, sb.neg_tokens);
        if (sb.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

[ascii_dec_hex_converter_core.f]
hdl/ahx_pkg.sv
hdl/ahx_accum.sv
hdl/ascii_dec_hex_converter_core.sv
test/tb.sv
